>>> design/bls_pkg.sv
// Shared types and constants of the bilinear sampler.
package bls_pkg;

  localparam int CH_W     = 16;
  localparam int NUM_CH   = 4;
  localparam int COORD_W  = 32;
  localparam int COL_W    = 8;
  localparam int ROW_W    = 7;
  localparam int CFG_W_W  = 9;
  localparam int CFG_H_W  = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  // Channel positions inside a pixel word.
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  // Item kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
  localparam logic [CFG_H_W-1:0] IMAGE_HEIGHT_RST = 8'd128;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  // Load enables of the pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

>>> design/bls_if.sv
// Request and response channel interfaces of the bilinear sampler.
interface bls_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         pixel_col;
  logic [6:0]         pixel_row;
  logic [15:0]        in_red;
  logic [15:0]        in_green;
  logic [15:0]        in_blue;
  logic [15:0]        in_alpha;
  logic signed [31:0] coord_u;
  logic signed [31:0] coord_v;

  modport source (
    output valid, kind, pixel_col, pixel_row, in_red, in_green, in_blue, in_alpha,
           coord_u, coord_v,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel_col, pixel_row, in_red, in_green, in_blue, in_alpha,
           coord_u, coord_v,
    output ready
  );
endinterface

interface bls_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

>>> design/bls_map.sv
// Coordinate mapping and neighbour address generation, two register stages.
module bls_map
  import bls_pkg::*;
#(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 128,
  parameter int FRAC_BITS = 16,
  localparam int AW = $clog2(MAX_COLS * MAX_ROWS)
) (
  input  logic                   clk,
  input  pipe_en_t               en,
  input  logic [CFG_W_W-1:0]     cfg_width,
  input  logic [CFG_H_W-1:0]     cfg_height,
  input  logic [COL_W-1:0]       pixel_col,
  input  logic [ROW_W-1:0]       pixel_row,
  input  pixel_t                 pixel_in,
  input  logic signed [COORD_W-1:0] coord_u,
  input  logic signed [COORD_W-1:0] coord_v,
  output logic                   wr_ok,
  output logic [AW-1:0]          wr_addr,
  output pixel_t                 wr_data,
  output logic [AW-1:0]          addr00,
  output logic [AW-1:0]          addr10,
  output logic [AW-1:0]          addr01,
  output logic [AW-1:0]          addr11,
  output logic [FRAC_BITS-1:0]   frac_x,
  output logic [FRAC_BITS-1:0]   frac_y
);

  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int XPW = FRAC_BITS + CW;
  localparam int YPW = FRAC_BITS + 1 + RW;
  localparam logic [COORD_W-1:0] ONE = COORD_W'(2 ** FRAC_BITS);

  logic [CW-1:0]        w_sat, wm1;
  logic [RW-1:0]        h_sat, hm1;
  logic [FRAC_BITS:0]   v_clamp;
  logic [XPW-1:0]       x_next;
  logic [YPW-1:0]       y_next;
  logic                 wr_ok_next;
  logic [AW-1:0]        wr_addr_next;

  // First stage registers.
  logic [XPW-1:0]       x_s1;
  logic [YPW-1:0]       y_s1;
  logic                 wr_ok_s1;
  logic [AW-1:0]        wr_addr_s1;
  pixel_t               wr_data_s1;

  logic [CW-1:0]        x0_raw, x0, x1;
  logic [RW:0]          y0_raw;
  logic [RW-1:0]        y0, y1;

  // Register values are saturated into the range the store can hold.
  always_comb begin
    if (cfg_width == '0) begin
      w_sat = CW'(1);
    end else if (int'(cfg_width) > MAX_COLS) begin
      w_sat = CW'(MAX_COLS);
    end else begin
      w_sat = CW'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_sat = RW'(1);
    end else if (int'(cfg_height) > MAX_ROWS) begin
      h_sat = RW'(MAX_ROWS);
    end else begin
      h_sat = RW'(cfg_height);
    end
    wm1 = w_sat - CW'(1);
    hm1 = h_sat - RW'(1);
  end

  // u keeps only its fraction; v is clamped to the closed unit interval.
  always_comb begin
    if (coord_v[COORD_W-1]) begin
      v_clamp = '0;
    end else if ($unsigned(coord_v) > ONE) begin
      v_clamp = ONE[FRAC_BITS:0];
    end else begin
      v_clamp = coord_v[FRAC_BITS:0];
    end
    x_next       = XPW'(coord_u[FRAC_BITS-1:0]) * XPW'(wm1);
    y_next       = YPW'(v_clamp) * YPW'(hm1);
    wr_ok_next   = (int'(pixel_col) < MAX_COLS) && (int'(pixel_row) < MAX_ROWS);
    wr_addr_next = AW'(pixel_row) * AW'(MAX_COLS) + AW'(pixel_col);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      x_s1       <= x_next;
      y_s1       <= y_next;
      wr_ok_s1   <= wr_ok_next;
      wr_addr_s1 <= wr_addr_next;
      wr_data_s1 <= pixel_in;
    end
  end

  // Integer parts pick the neighbours: x wraps, y clamps at the last row.
  always_comb begin
    x0_raw = x_s1[XPW-1:FRAC_BITS];
    x0     = (x0_raw >= w_sat) ? wm1 : x0_raw;
    x1     = ((x0 + CW'(1)) == w_sat) ? '0 : x0 + CW'(1);
    y0_raw = y_s1[YPW-1:FRAC_BITS];
    y0     = (y0_raw >= (RW+1)'(h_sat)) ? hm1 : y0_raw[RW-1:0];
    y1     = ((y0 + RW'(1)) < h_sat) ? y0 + RW'(1) : hm1;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      wr_ok   <= wr_ok_s1;
      wr_addr <= wr_addr_s1;
      wr_data <= wr_data_s1;
      addr00  <= AW'(y0) * AW'(MAX_COLS) + AW'(x0);
      addr10  <= AW'(y0) * AW'(MAX_COLS) + AW'(x1);
      addr01  <= AW'(y1) * AW'(MAX_COLS) + AW'(x0);
      addr11  <= AW'(y1) * AW'(MAX_COLS) + AW'(x1);
      frac_x  <= x_s1[FRAC_BITS-1:0];
      frac_y  <= y_s1[FRAC_BITS-1:0];
    end
  end

endmodule

>>> design/bls_store.sv
// Pixel store: two copies, each with one write port and two read ports.
module bls_store
  import bls_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128,
  localparam int DEPTH = MAX_COLS * MAX_ROWS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pixel_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] addr00,
  input  logic [AW-1:0] addr10,
  input  logic [AW-1:0] addr01,
  input  logic [AW-1:0] addr11,
  output pixel_t        pix00,
  output pixel_t        pix10,
  output pixel_t        pix01,
  output pixel_t        pix11
);

  // The upper copy serves the first neighbour row, the lower copy the second.
  pixel_t mem_upper [DEPTH];
  pixel_t mem_lower [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr] <= wr_data;
      mem_lower[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pix00 <= mem_upper[addr00];
      pix10 <= mem_upper[addr10];
      pix01 <= mem_lower[addr01];
      pix11 <= mem_lower[addr11];
    end
  end

endmodule

>>> design/bls_filter.sv
// Horizontal then vertical interpolation of all four channels.
module bls_filter
  import bls_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  pipe_en_t             en,
  input  logic [FRAC_BITS-1:0] frac_x,
  input  logic [FRAC_BITS-1:0] frac_y,
  input  logic                 blank,
  input  pixel_t               pix00,
  input  pixel_t               pix10,
  input  pixel_t               pix01,
  input  pixel_t               pix11,
  output pixel_t               result
);

  localparam int PW = CH_W + FRAC_BITS + 2;
  localparam logic signed [PW-1:0] HALF = PW'(2 ** (FRAC_BITS - 1));

  // a + round_half_up((b - a) * f / 2^F); equal to the two-weight form
  // because a * 2^F is an exact multiple of the divisor.
  function automatic logic [CH_W-1:0] lerp(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input logic [FRAC_BITS-1:0] f);
    logic signed [CH_W:0]   diff;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   step;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, f});
    step = (prod + HALF) >>> FRAC_BITS;
    return a + step[CH_W-1:0];
  endfunction

  logic [FRAC_BITS-1:0] frac_x_s3, frac_y_s3, frac_y_s4;
  logic                 blank_s3, blank_s4;
  pixel_t               row0_s4, row1_s4;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      frac_x_s3 <= frac_x;
      frac_y_s3 <= frac_y;
      blank_s3  <= blank;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      frac_y_s4 <= frac_y_s3;
      blank_s4  <= blank_s3;
      for (int c = 0; c < NUM_CH; c++) begin
        row0_s4[c] <= lerp(pix00[c], pix10[c], frac_x_s3);
        row1_s4[c] <= lerp(pix01[c], pix11[c], frac_x_s3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      for (int c = 0; c < NUM_CH; c++) begin
        result[c] <= blank_s4 ? '0 : lerp(row0_s4[c], row1_s4[c], frac_y_s4);
      end
    end
  end

endmodule

>>> design/bilinear_sampler_wrap_clamp_top.sv
// Top level of the bilinear sampler with horizontal wrap and vertical clamp.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req.valid/ready    kind, pixel position, RGBA, u, v
//   rsp      out        rsp.valid/ready    interpolated RGBA, one per sample
//   cfg      in         cfg_wr_en          image_width (0), image_height (1)
//
// One item is taken per clock while the pipeline does not stall. A sample transfer
// passes through two stages of coordinate mapping, one store read, and one horizontal
// and one vertical interpolation stage, the last being the output register, whose
// contents make the response transfer once rsp.ready is high.
// The rate is set by the store, which is kept as two copies so that each copy
// serves two of the four neighbours through its two read ports.
// Reset clears the pipeline valids, the loaded flag and the registers; the store
// is not cleared and needs no clearing pass. req.ready is held low during reset.
// A stall on rsp holds the output register and every full stage with no empty
// stage ahead of it, so req.ready falls only once all five stages are full.
module bilinear_sampler_wrap_clamp_top
  import bls_pkg::*;
#(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 128,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bls_req_if.sink               req,
  bls_rsp_if.source             rsp
);

  localparam int AW = $clog2(MAX_COLS * MAX_ROWS);

  logic [CFG_W_W-1:0] image_width;
  logic [CFG_H_W-1:0] image_height;
  logic               image_loaded;

  // Stage valids and item kinds travelling alongside the datapath.
  logic     valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
  logic     kind_s1, kind_s2, kind_s3;
  pipe_en_t en;

  pixel_t               pixel_in;
  logic                 wr_ok;
  logic [AW-1:0]        wr_addr;
  pixel_t               wr_data;
  logic [AW-1:0]        addr00, addr10, addr01, addr11;
  logic [FRAC_BITS-1:0] frac_x, frac_y;
  logic                 store_wr;
  pixel_t               pix00, pix10, pix01, pix11;
  pixel_t               result;

  // The user must write configuration only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_H_W-1:0];
      endcase
    end
  end

  // A stage takes new contents when it is empty or its own contents move on.
  always_comb begin
    en.s5 = !valid_s5 || rsp.ready;
    en.s4 = !valid_s4 || en.s5;
    en.s3 = !valid_s3 || en.s4;
    en.s2 = !valid_s2 || en.s3;
    en.s1 = !valid_s1 || en.s2;
  end

  assign req.ready = en.s1 && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid_s2 <= 1'b0;
      valid_s3 <= 1'b0;
      valid_s4 <= 1'b0;
      valid_s5 <= 1'b0;
    end else begin
      if (en.s1) valid_s1 <= req.valid;
      if (en.s2) valid_s2 <= valid_s1;
      if (en.s3) valid_s3 <= valid_s2;
      // Load items end at the store and leave no result behind.
      if (en.s4) valid_s4 <= valid_s3 && (kind_s3 == KIND_SAMPLE);
      if (en.s5) valid_s5 <= valid_s4;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) kind_s1 <= req.kind;
    if (en.s2) kind_s2 <= kind_s1;
    if (en.s3) kind_s3 <= kind_s2;
  end

  // Loads write the store at the same stage where samples read it, so every
  // access happens in transfer order and no forwarding path is needed. The
  // loaded flag is updated at that stage too, for the same reason.
  assign store_wr = en.s3 && valid_s2 && (kind_s2 == KIND_LOAD) && wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_loaded <= 1'b0;
    end else if (en.s3 && valid_s2 && (kind_s2 == KIND_LOAD)) begin
      image_loaded <= 1'b1;
    end
  end

  always_comb begin
    pixel_in           = '0;
    pixel_in[CH_RED]   = req.in_red;
    pixel_in[CH_GREEN] = req.in_green;
    pixel_in[CH_BLUE]  = req.in_blue;
    pixel_in[CH_ALPHA] = req.in_alpha;
  end

  bls_map #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_map (
    .clk        (clk),
    .en         (en),
    .cfg_width  (image_width),
    .cfg_height (image_height),
    .pixel_col  (req.pixel_col),
    .pixel_row  (req.pixel_row),
    .pixel_in   (pixel_in),
    .coord_u    (req.coord_u),
    .coord_v    (req.coord_v),
    .wr_ok      (wr_ok),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .addr00     (addr00),
    .addr10     (addr10),
    .addr01     (addr01),
    .addr11     (addr11),
    .frac_x     (frac_x),
    .frac_y     (frac_y)
  );

  bls_store #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (en.s3),
    .addr00  (addr00),
    .addr10  (addr10),
    .addr01  (addr01),
    .addr11  (addr11),
    .pix00   (pix00),
    .pix10   (pix10),
    .pix01   (pix01),
    .pix11   (pix11)
  );

  // A sample taken before any load is blanked to zero at the output.
  bls_filter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_filter (
    .clk    (clk),
    .en     (en),
    .frac_x (frac_x),
    .frac_y (frac_y),
    .blank  (!image_loaded),
    .pix00  (pix00),
    .pix10  (pix10),
    .pix01  (pix01),
    .pix11  (pix11),
    .result (result)
  );

  assign rsp.valid     = valid_s5;
  assign rsp.out_red   = result[CH_RED];
  assign rsp.out_green = result[CH_GREEN];
  assign rsp.out_blue  = result[CH_BLUE];
  assign rsp.out_alpha = result[CH_ALPHA];

endmodule

>>> test/bilinear_sampler_wrap_clamp_top_tb.sv
// Self-checking testbench of the bilinear sampler with horizontal wrap and vertical clamp.
`timescale 1ns / 1ps

module bilinear_sampler_wrap_clamp_top_tb;
  import bls_pkg::*;

  // The block is built with its default store size and 16 fraction bits; the
  // predictor below shares those sizes.
  localparam int STORE_COLS   = 256;
  localparam int STORE_ROWS   = 128;
  localparam int QUIET_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int ITEMS_PER_PHASE = 5;
  localparam int FIXED_PHASES = 7;
  localparam int RANDOM_PHASES = 4;

  // One input transfer on the request channel.
  typedef struct packed {
    logic        kind;
    logic [7:0]  col;
    logic [6:0]  row;
    pixel_t      rgba;
    logic [31:0] u;
    logic [31:0] v;
  } bls_item_t;

  // One row of the directed table: either a register update or an item, the
  // latter optionally with its result written out by hand.
  typedef struct {
    bit                  is_cfg;
    logic [CFG_DATA_W-1:0] w_data;
    logic [CFG_DATA_W-1:0] h_data;
    bls_item_t           item;
    bit                  has_want;
    pixel_t              want;
  } dir_step_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bls_req_if req_ch ();
  bls_rsp_if rsp_ch ();

  bilinear_sampler_wrap_clamp_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #2 clk = ~clk;

  // Predictor state: a private copy of the image, the loaded flag and the two
  // size registers, together with a record of which pixels hold known data.
  pixel_t           img_store   [STORE_COLS*STORE_ROWS];
  bit               img_written [STORE_COLS*STORE_ROWS];
  bit               img_loaded;
  logic [CFG_W_W-1:0] img_width;
  logic [CFG_H_W-1:0] img_height;

  // Interpolated pixels still owed by the block, oldest first.
  pixel_t pending_samples [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned rsp_hold = 0;
  bit          send_stalls;
  bit          rsp_stalls;

  string chan_name [NUM_CH] = '{"out_red", "out_green", "out_blue", "out_alpha"};

  // One step of linear interpolation with 16 fraction bits, rounding half up.
  function automatic logic [15:0] lerp16(logic [15:0] a, logic [15:0] b, logic [15:0] f);
    logic [63:0] acc;
    acc = 64'(a) * (64'd65536 - 64'(f)) + 64'(b) * 64'(f) + 64'd32768;
    return acc[31:16];
  endfunction

  // Expected colour of a sample at (u, v) under the current image and sizes.
  function automatic pixel_t sample_image(logic [31:0] u, logic [31:0] v);
    int unsigned w, h, x0, x1, y0, y1;
    logic [31:0] vc;
    logic [63:0] xs, ys;
    logic [15:0] fx, fy;
    pixel_t p00, p10, p01, p11, res;
    if (!img_loaded) return '0;
    // Out-of-range register values are pulled back into the usable range.
    w = (img_width == 0) ? 1 : (img_width > STORE_COLS) ? STORE_COLS : img_width;
    h = (img_height == 0) ? 1 : (img_height > STORE_ROWS) ? STORE_ROWS : img_height;
    // u keeps only its fraction, so it wraps; v is clamped to zero..one.
    if (v[31]) vc = '0;
    else if (v > 32'h0001_0000) vc = 32'h0001_0000;
    else vc = v;
    xs = 64'(u[15:0]) * 64'(w - 1);
    ys = 64'(vc) * 64'(h - 1);
    x0 = xs[47:16];
    fx = xs[15:0];
    y0 = ys[47:16];
    fy = ys[15:0];
    if (x0 >= w) x0 = w - 1;
    if (y0 >= h) y0 = h - 1;
    x1 = (x0 + 1) % w;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    p00 = img_store[y0 * STORE_COLS + x0];
    p10 = img_store[y0 * STORE_COLS + x1];
    p01 = img_store[y1 * STORE_COLS + x0];
    p11 = img_store[y1 * STORE_COLS + x1];
    for (int c = 0; c < NUM_CH; c++) begin
      res[c] = lerp16(lerp16(p00[c], p10[c], fx), lerp16(p01[c], p11[c], fx), fy);
    end
    return res;
  endfunction

  function automatic pixel_t rgba(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                  logic [15:0] a);
    pixel_t p;
    p[CH_RED]   = r;
    p[CH_GREEN] = g;
    p[CH_BLUE]  = b;
    p[CH_ALPHA] = a;
    return p;
  endfunction

  function automatic pixel_t rand_pixel();
    return pixel_t'({$urandom(), $urandom()});
  endfunction

  // Load items carry junk in the coordinate fields, which the block must ignore.
  function automatic bls_item_t load_item(int unsigned col, int unsigned row, pixel_t p);
    bls_item_t it;
    it.kind = KIND_LOAD;
    it.col  = col[7:0];
    it.row  = row[6:0];
    it.rgba = p;
    it.u    = $urandom();
    it.v    = $urandom();
    return it;
  endfunction

  // Sample items likewise carry junk in the pixel fields.
  function automatic bls_item_t sample_item(logic [31:0] u, logic [31:0] v);
    bls_item_t it;
    it.kind = KIND_SAMPLE;
    it.col  = 8'($urandom_range(0, 255));
    it.row  = 7'($urandom_range(0, 127));
    it.rgba = rand_pixel();
    it.u    = u;
    it.v    = v;
    return it;
  endfunction

  function automatic logic [31:0] rand_u();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h0000_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Most v values fall inside zero..one so that the rows are blended; the rest
  // hit the clamp from both sides.
  function automatic logic [31:0] rand_v();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 32'h0001_0000);
      4: return 32'h0000_0000;
      5: return 32'h0001_0000;
      6: return 32'h8000_0000;
      7: return 32'h7FFF_FFFF;
      8: return $urandom();
      default: return 32'h0001_0000 + $urandom_range(1, 1000);
    endcase
  endfunction

  // Idle length: mostly short, sometimes medium, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dir_step_t step_item(bls_item_t it);
    dir_step_t s;
    s = '{default: '0};
    s.item = it;
    return s;
  endfunction

  function automatic dir_step_t step_check(bls_item_t it, pixel_t want);
    dir_step_t s;
    s = step_item(it);
    s.has_want = 1'b1;
    s.want     = want;
    return s;
  endfunction

  function automatic dir_step_t step_cfg(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    dir_step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.w_data = w;
    s.h_data = h;
    return s;
  endfunction

  // Offers one item, waits for the transfer, then updates the predictor. valid
  // is left high afterwards so that back-to-back items need no second assignment
  // within the same time step.
  task automatic send_item(bls_item_t it, bit has_want, pixel_t want);
    int unsigned idle;
    int unsigned idx;
    idle = (send_stalls && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (idle != 0) begin
      req_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= it.kind;
    req_ch.pixel_col <= it.col;
    req_ch.pixel_row <= it.row;
    req_ch.in_red    <= it.rgba[CH_RED];
    req_ch.in_green  <= it.rgba[CH_GREEN];
    req_ch.in_blue   <= it.rgba[CH_BLUE];
    req_ch.in_alpha  <= it.rgba[CH_ALPHA];
    req_ch.coord_u   <= it.u;
    req_ch.coord_v   <= it.v;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (it.kind == KIND_LOAD) begin
      idx = it.row * STORE_COLS + it.col;
      img_store[idx]   = it.rgba;
      img_written[idx] = 1'b1;
      img_loaded       = 1'b1;
    end else begin
      pending_samples.push_back(has_want ? want : sample_image(it.u, it.v));
    end
  endtask

  // Stops offering items and waits until every owed result has come back, then
  // gives any trailing load time to leave the pipeline.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Both size registers are written on every change; height keeps only eight bits.
  task automatic write_regs(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    img_width  = w;
    img_height = h[CFG_H_W-1:0];
  endtask

  // Loads every pixel of the active region that has never been written, so that
  // no sample ever reaches an undefined store entry.
  task automatic fill_region();
    int unsigned w, h;
    w = (img_width == 0) ? 1 : (img_width > STORE_COLS) ? STORE_COLS : img_width;
    h = (img_height == 0) ? 1 : (img_height > STORE_ROWS) ? STORE_ROWS : img_height;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (!img_written[r * STORE_COLS + c]) send_item(load_item(c, r, rand_pixel()), 0, '0);
      end
    end
  endtask

  // Result checker: every response transfer is matched against the oldest
  // expectation, channel by channel.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got[CH_RED]   = rsp_ch.out_red;
      got[CH_GREEN] = rsp_ch.out_green;
      got[CH_BLUE]  = rsp_ch.out_blue;
      got[CH_ALPHA] = rsp_ch.out_alpha;
      if (pending_samples.size() == 0) begin
        $display("%0t: result with none expected: expected nothing, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        for (int c = 0; c < NUM_CH; c++) begin
          if (got[c] !== want[c]) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, chan_name[c],
                     want[c], got[c]);
            errors++;
          end
        end
      end
    end
  end

  // Receiver back-pressure. When stalls are enabled, ready drops for a random idle
  // length at random points; otherwise it stays high.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_hold != 0) begin
      rsp_hold <= rsp_hold - 1;
    end else if (!rsp_stalls || $urandom_range(0, 99) < 65) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_ch.ready <= 1'b0;
      rsp_hold     <= pick_gap() - 1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("bilinear_sampler_wrap_clamp_top verification failed");
      $finish;
    end
  end

  // Stimulus: directed table first, then phases of random traffic under a range
  // of image sizes, the extremes among them.
  initial begin
    dir_step_t steps [$];
    pixel_t p00, p10, p01, p11;
    logic [CFG_DATA_W-1:0] phase_w [FIXED_PHASES];
    logic [CFG_DATA_W-1:0] phase_h [FIXED_PHASES];
    logic [CFG_DATA_W-1:0] w_data, h_data;
    int unsigned w, h, sel;

    send_stalls = 1'b1;
    rsp_stalls  = 1'b1;
    img_loaded  = 1'b0;
    img_width   = IMAGE_WIDTH_RST;
    img_height  = IMAGE_HEIGHT_RST;
    foreach (img_written[i]) img_written[i] = 1'b0;

    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= REG_IMAGE_WIDTH;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    req_ch.kind  <= KIND_LOAD;
    req_ch.pixel_col <= '0;
    req_ch.pixel_row <= '0;
    req_ch.in_red    <= '0;
    req_ch.in_green  <= '0;
    req_ch.in_blue   <= '0;
    req_ch.in_alpha  <= '0;
    req_ch.coord_u   <= '0;
    req_ch.coord_v   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Corner pixels of a two by two image: all zeros, all ones and two mixed.
    p00 = rgba(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    p10 = rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    p01 = rgba(16'h1234, 16'hABCD, 16'h00FF, 16'hFF00);
    p11 = rgba(16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA);

    // Before any load the block answers with black, whatever the coordinates.
    steps.push_back(step_check(sample_item(32'h0000_0000, 32'h0000_0000), '0));
    steps.push_back(step_check(sample_item(32'h7FFF_FFFF, 32'h8000_0000), '0));
    steps.push_back(step_cfg(9'd2, 9'd2));
    steps.push_back(step_item(load_item(0, 0, p00)));
    steps.push_back(step_item(load_item(1, 0, p10)));
    steps.push_back(step_item(load_item(0, 1, p01)));
    steps.push_back(step_item(load_item(1, 1, p11)));
    // The origin lands exactly on the top-left pixel.
    steps.push_back(step_check(sample_item(32'h0000_0000, 32'h0000_0000), p00));
    // Largest fraction of u with v clamped from above.
    steps.push_back(step_item(sample_item(32'h0000_FFFF, 32'h7FFF_FFFF)));
    // A negative whole u wraps to zero; v of exactly one selects the last row.
    steps.push_back(step_check(sample_item(32'h8000_0000, 32'h0001_0000), p01));
    // Negative fractions: u wraps to one half, v clamps to zero.
    steps.push_back(step_item(sample_item(32'hFFFF_8000, 32'hFFFF_FFFF)));
    steps.push_back(step_item(sample_item(32'h0000_8000, 32'h0000_8000)));
    // Loads outside the active region, up to the far corner of the store.
    steps.push_back(step_item(load_item(200, 100, rand_pixel())));
    steps.push_back(step_item(load_item(255, 127, p10)));
    // A width of one puts both neighbours in column zero; a height of zero is
    // raised to one.
    steps.push_back(step_cfg(9'd1, 9'd0));
    steps.push_back(step_check(sample_item(32'h1234_5678, 32'h0001_0000), p00));
    steps.push_back(step_cfg(9'd3, 9'd2));
    steps.push_back(step_item(load_item(2, 0, rand_pixel())));
    steps.push_back(step_item(load_item(2, 1, rand_pixel())));
    steps.push_back(step_item(sample_item(32'h0000_FFFF, 32'h0000_0000)));
    steps.push_back(step_item(sample_item(32'hFFFF_FFFF, 32'h0000_C000)));

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        settle();
        write_regs(steps[i].w_data, steps[i].h_data);
      end else begin
        send_item(steps[i].item, steps[i].has_want, steps[i].want);
      end
    end

    // Fixed sizes cover the saturation of both registers at both ends, exact
    // maximum values and a few small shapes; the wide and tall shapes share their
    // first row and column so that only two large fills are needed.
    phase_w = '{9'd4, 9'd511, 9'd0,   9'd256, 9'd1,   9'd7, 9'd2};
    phase_h = '{9'd3, 9'd0,   9'h1FF, 9'd1,   9'd128, 9'd5, 9'd2};

    for (int ph = 0; ph < FIXED_PHASES + RANDOM_PHASES; ph++) begin
      if (ph < FIXED_PHASES) begin
        w_data = phase_w[ph];
        h_data = phase_h[ph];
      end else begin
        // Small random shapes inside the seven by five area that is already
        // loaded; bit 8 of the height data must be dropped.
        w_data = 9'($urandom_range(1, 7));
        h_data = {1'($urandom_range(0, 1)), 8'($urandom_range(1, 5))};
      end
      // Some phases run without any idling on one side or the other.
      send_stalls = (ph % 4) != 1;
      rsp_stalls  = (ph % 3) != 2;
      settle();
      write_regs(w_data, h_data);
      fill_region();
      w = (img_width == 0) ? 1 : (img_width > STORE_COLS) ? STORE_COLS : img_width;
      h = (img_height == 0) ? 1 : (img_height > STORE_ROWS) ? STORE_ROWS : img_height;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then the sender holds off until every result is back.
        if (n == ITEMS_PER_PHASE / 2 && ph % 3 == 0) settle();
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          send_item(sample_item(rand_u(), rand_v()), 0, '0);
        end else if (sel < 90) begin
          // Overwrites inside the region, often right before a sample reads them.
          send_item(load_item($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                              rand_pixel()), 0, '0);
        end else begin
          send_item(load_item($urandom_range(0, 255), $urandom_range(0, 127),
                              rand_pixel()), 0, '0);
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("bilinear_sampler_wrap_clamp_top verification clean");
    end else begin
      $display("bilinear_sampler_wrap_clamp_top verification failed");
    end
    $finish;
  end

endmodule
